>>> sv/ddspc_pkg.sv
// Package for the differential-drive steering and PI speed controller.
// Holds field widths, register indexes, heading codes and the PI step function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ddspc_pkg;

  // Fixed-point fraction bits of the gains and the integrators.
  localparam int FracBits = 20;

  // Field widths.
  localparam int SensW   = 12;
  localparam int CodeW   = 8;
  localparam int SpeedW  = 16;
  localparam int DutyW   = 12;
  localparam int SetpW   = 14;
  localparam int HeadW   = 3;
  localparam int VelW    = 8;
  localparam int KpW     = 20;
  localparam int KiW     = 16;
  localparam int OffW    = 8;
  localparam int IntegW  = 34;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 20;
  localparam int InDataW  = 64;
  localparam int OutDataW = 56;

  // Derived datapath widths.
  localparam int MagW      = SetpW - 1;
  localparam int ErrW      = SpeedW + 1;
  localparam int PropW     = KpW + ErrW;
  localparam int IprodW    = KiW + ErrW;
  localparam int AccW      = IntegW + 1;
  localparam int SumW      = ((PropW > IntegW) ? PropW : IntegW) + 1;
  localparam int TruncW    = SumW - FracBits;
  localparam int DutyWideW = TruncW + 1;

  localparam int SpeedScale = 31;
  localparam int ClearLimit = 100;
  localparam int DutyMax    = 2047;
  localparam int DutyMin    = -2048;

  localparam logic signed [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
  localparam logic signed [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};
  localparam logic signed [SumW-1:0] FracMask =
    SumW'((64'd1 << FracBits) - 64'd1);
  localparam logic signed [SumW-1:0] ClearLim =
    SumW'(64'(ClearLimit) << FracBits);
  localparam logic signed [SumW-1:0] ClearLimNeg = -ClearLim;
  localparam logic signed [DutyWideW-1:0] DutyMaxW = DutyWideW'(DutyMax);
  localparam logic signed [DutyWideW-1:0] DutyMinW = DutyWideW'(DutyMin);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRunEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDriveMode = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgVelocity  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPropGain  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgIntegGain = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDutyOff   = 3'd6;

  // Drive modes.
  localparam logic [CodeW-1:0] ModeAvoid  = 8'd1;
  localparam logic [CodeW-1:0] ModeManual = 8'd2;

  // Heading codes.
  localparam logic [HeadW-1:0] HeadStop     = 3'd0;
  localparam logic [HeadW-1:0] HeadForward  = 3'd1;
  localparam logic [HeadW-1:0] HeadLeft     = 3'd2;
  localparam logic [HeadW-1:0] HeadRight    = 3'd3;
  localparam logic [HeadW-1:0] HeadBackward = 3'd4;

  typedef struct packed {
    logic signed [IntegW-1:0] integ;
    logic signed [DutyW-1:0]  duty;
  } pi_res_t;

  // One PI step of one wheel: new integrator and saturated duty command.
  function automatic pi_res_t pi_step(
    input logic signed [SetpW-1:0]  target,
    input logic signed [SpeedW-1:0] speed,
    input logic signed [IntegW-1:0] integ,
    input logic [KpW-1:0]           kp,
    input logic [KiW-1:0]           ki,
    input logic [OffW-1:0]          offset
  );
    logic signed [ErrW-1:0]      err;
    logic signed [PropW-1:0]     prop;
    logic signed [IprodW-1:0]    iprod;
    logic signed [AccW-1:0]      acc;
    logic signed [IntegW-1:0]    integ_sat;
    logic signed [SumW-1:0]      sum;
    logic signed [SumW-1:0]      biased;
    logic signed [TruncW-1:0]    trunc;
    logic signed [DutyWideW-1:0] duty_w;
    pi_res_t                     res;
    err   = ErrW'(target) - ErrW'(speed);
    prop  = signed'(PropW'(kp)) * PropW'(err);
    iprod = signed'(IprodW'(ki)) * IprodW'(err);
    acc   = AccW'(integ) + AccW'(iprod);
    if (acc[AccW-1] != acc[AccW-2]) begin
      integ_sat = acc[AccW-1] ? IntegMin : IntegMax;
    end else begin
      integ_sat = acc[IntegW-1:0];
    end
    sum    = SumW'(prop) + SumW'(integ_sat);
    biased = sum + (sum[SumW-1] ? FracMask : '0);
    trunc  = biased[SumW-1:FracBits];
    duty_w = DutyWideW'(trunc) + signed'(DutyWideW'(offset));
    if (duty_w > DutyMaxW) begin
      res.duty = DutyW'(DutyMaxW);
    end else if (duty_w < DutyMinW) begin
      res.duty = DutyW'(DutyMinW);
    end else begin
      res.duty = duty_w[DutyW-1:0];
    end
    if (sum > ClearLim || sum < ClearLimNeg) begin
      res.integ = '0;
    end else begin
      res.integ = integ_sat;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> sv/diff_drive_steer_pi_control_top.sv
// Usage notes for the differential-drive steering and PI speed controller.
// The slave stream takes one control tick per item: both front readings, the
// manual direction code and both measured wheel speeds. The master stream
// returns one item per tick: both duty commands, both setpoints and heading.
// The configuration channel writes one register per handshake and is always
// ready; the user must write it only while no tick is in flight (unchecked).
// An accepted item is held in an input register, the setpoint choice and both
// PI steps are worked out in a single combinational pass, and the result lands
// in the output register, from which it is offered on the master stream.
// One item per cycle is sustained while the receiver takes each result; the
// rate is set by the integrator and setpoint registers, which close their
// loop in that one pass.
// When the receiver stalls, the output register holds its item and the input
// register takes one more; after that the slave ready falls until the output
// drains. Reset clears both valid flags, both setpoints, both integrators and
// the heading, and loads the register defaults.
// Depends on ddspc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module diff_drive_steer_pi_control_top (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // tdata: front_sensor_a, front_sensor_b, manual_direction, speed_right,
  // speed_left
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [ddspc_pkg::InDataW-1:0]       s_axis_tdata,
  // tdata: duty_right, duty_left, target_right, target_left, heading_code,
  // zero pad
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [ddspc_pkg::OutDataW-1:0]      m_axis_tdata,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [ddspc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire  [ddspc_pkg::CfgDatW-1:0]       cfg_data_i
);

  logic                              run_enable_q;
  logic [ddspc_pkg::CodeW-1:0]       drive_mode_q;
  logic [ddspc_pkg::VelW-1:0]        velocity_q;
  logic [ddspc_pkg::SensW-1:0]       threshold_q;
  logic [ddspc_pkg::KpW-1:0]         prop_gain_q;
  logic [ddspc_pkg::KiW-1:0]         integ_gain_q;
  logic [ddspc_pkg::OffW-1:0]        duty_offset_q;

  logic                              in_valid_q;
  logic [ddspc_pkg::SensW-1:0]       sens_a_q;
  logic [ddspc_pkg::SensW-1:0]       sens_b_q;
  logic [ddspc_pkg::CodeW-1:0]       manual_q;
  logic signed [ddspc_pkg::SpeedW-1:0] speed_r_q;
  logic signed [ddspc_pkg::SpeedW-1:0] speed_l_q;

  logic                              out_valid_q;
  logic [ddspc_pkg::OutDataW-1:0]    out_data_q;
  logic [ddspc_pkg::OutDataW-1:0]    out_data_d;

  logic signed [ddspc_pkg::SetpW-1:0]  sp_r_q, sp_r_d;
  logic signed [ddspc_pkg::SetpW-1:0]  sp_l_q, sp_l_d;
  logic signed [ddspc_pkg::IntegW-1:0] integ_r_q;
  logic signed [ddspc_pkg::IntegW-1:0] integ_l_q;
  logic [ddspc_pkg::HeadW-1:0]         heading_q, heading_d;

  logic                              s_acc;
  logic                              advance;
  logic                              upd;
  logic [ddspc_pkg::HeadW-1:0]       code;
  logic [ddspc_pkg::MagW-1:0]        mag;
  logic signed [ddspc_pkg::SetpW-1:0] vel;
  logic                              obst_a;
  logic                              obst_b;
  ddspc_pkg::pi_res_t                pi_r;
  ddspc_pkg::pi_res_t                pi_l;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_enable_q  <= 1'b0;
      drive_mode_q  <= ddspc_pkg::ModeAvoid;
      velocity_q    <= '0;
      threshold_q   <= ddspc_pkg::SensW'(600);
      prop_gain_q   <= ddspc_pkg::KpW'(31457);
      integ_gain_q  <= ddspc_pkg::KiW'(2735);
      duty_offset_q <= ddspc_pkg::OffW'(100);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ddspc_pkg::CfgRunEnable: run_enable_q  <= cfg_data_i[0];
        ddspc_pkg::CfgDriveMode: drive_mode_q  <= cfg_data_i[ddspc_pkg::CodeW-1:0];
        ddspc_pkg::CfgVelocity:  velocity_q    <= cfg_data_i[ddspc_pkg::VelW-1:0];
        ddspc_pkg::CfgThreshold: threshold_q   <= cfg_data_i[ddspc_pkg::SensW-1:0];
        ddspc_pkg::CfgPropGain:  prop_gain_q   <= cfg_data_i[ddspc_pkg::KpW-1:0];
        ddspc_pkg::CfgIntegGain: integ_gain_q  <= cfg_data_i[ddspc_pkg::KiW-1:0];
        ddspc_pkg::CfgDutyOff:   duty_offset_q <= cfg_data_i[ddspc_pkg::OffW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      sens_a_q  <= s_axis_tdata[11:0];
      sens_b_q  <= s_axis_tdata[23:12];
      manual_q  <= s_axis_tdata[31:24];
      speed_r_q <= s_axis_tdata[47:32];
      speed_l_q <= s_axis_tdata[63:48];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  always_comb begin
    mag    = ddspc_pkg::MagW'(velocity_q) * ddspc_pkg::MagW'(ddspc_pkg::SpeedScale);
    vel    = signed'({1'b0, mag});
    obst_a = sens_a_q > threshold_q;
    obst_b = sens_b_q > threshold_q;
    upd    = 1'b0;
    code   = ddspc_pkg::HeadStop;
    if (!run_enable_q) begin
      upd = 1'b1;
    end else begin
      unique case (drive_mode_q)
        ddspc_pkg::ModeAvoid: begin
          upd = 1'b1;
          if (obst_a && obst_b) begin
            code = ddspc_pkg::HeadBackward;
          end else if (obst_a) begin
            code = ddspc_pkg::HeadRight;
          end else if (obst_b) begin
            code = ddspc_pkg::HeadLeft;
          end else begin
            code = ddspc_pkg::HeadForward;
          end
        end
        ddspc_pkg::ModeManual: begin
          if (manual_q <= ddspc_pkg::CodeW'(ddspc_pkg::HeadBackward)) begin
            upd  = 1'b1;
            code = manual_q[ddspc_pkg::HeadW-1:0];
          end
        end
        default: ;
      endcase
    end

    sp_r_d    = sp_r_q;
    sp_l_d    = sp_l_q;
    heading_d = heading_q;
    if (upd) begin
      heading_d = code;
      case (code)
        ddspc_pkg::HeadStop: begin
          sp_r_d = '0;
          sp_l_d = '0;
        end
        ddspc_pkg::HeadForward: begin
          sp_r_d = vel;
          sp_l_d = vel;
        end
        ddspc_pkg::HeadLeft: begin
          sp_r_d = vel;
          sp_l_d = -vel;
        end
        ddspc_pkg::HeadRight: begin
          sp_r_d = -vel;
          sp_l_d = vel;
        end
        default: begin
          sp_r_d = -vel;
          sp_l_d = -vel;
        end
      endcase
    end

    pi_r = ddspc_pkg::pi_step(sp_r_d, speed_r_q, integ_r_q, prop_gain_q, integ_gain_q,
                              duty_offset_q);
    pi_l = ddspc_pkg::pi_step(sp_l_d, speed_l_q, integ_l_q, prop_gain_q, integ_gain_q,
                              duty_offset_q);
    out_data_d = {1'b0, heading_d, sp_l_d, sp_r_d, pi_l.duty, pi_r.duty};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sp_r_q      <= '0;
      sp_l_q      <= '0;
      integ_r_q   <= '0;
      integ_l_q   <= '0;
      heading_q   <= ddspc_pkg::HeadStop;
    end else begin
      if (s_acc) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        sp_r_q      <= sp_r_d;
        sp_l_q      <= sp_l_d;
        integ_r_q   <= pi_r.integ;
        integ_l_q   <= pi_l.integ;
        heading_q   <= heading_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_stop_means_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heading_q == ddspc_pkg::HeadStop |-> sp_r_q == '0 && sp_l_q == '0)
    else $error("stop heading with a non-zero setpoint");

  a_forward_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heading_q == ddspc_pkg::HeadForward |-> sp_r_q == sp_l_q && !sp_r_q[ddspc_pkg::SetpW-1])
    else $error("forward heading with unequal or negative setpoints");

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input held off while the pipeline can move");

  a_disable_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !run_enable_q |=> heading_q == ddspc_pkg::HeadStop)
    else $error("disabled tick did not leave the heading at stop");

  a_result_follows_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced item did not reach the output register");

endmodule

`default_nettype wire
